// File: src/bbrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur package
// Shared widths, reset values, register indexes and payload types of the
// 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bbrgb_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int PIX_W         = 8;
	localparam int CFG_W         = 16;
	localparam int WIDTH_REG_W   = 11;
	localparam int HEIGHT_REG_W  = 16;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	localparam int CSUM_W      = PIX_W + 2;
	localparam int TSUM_W      = PIX_W + 4;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(7282);

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [CSUM_W-1:0] red;
		logic [CSUM_W-1:0] green;
		logic [CSUM_W-1:0] blue;
	} csum_t;

	typedef struct packed {
		logic [TSUM_W-1:0] red;
		logic [TSUM_W-1:0] green;
		logic [TSUM_W-1:0] blue;
	} tsum_t;

endpackage

// File: src/bbrgb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur stream interfaces
// Valid/ready channels for incoming pixels and blurred result pixels.
// ----------------------------------------------------------------------------
interface bbrgb_pix_if import bbrgb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_red;
	logic [PIX_W-1:0] in_green;
	logic [PIX_W-1:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface bbrgb_res_if import bbrgb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic             run_last;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output run_last, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input run_last, output ready);
endinterface

// File: src/box_blur_3x3_rgb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 RGB box blur
// Streams pixels in raster order and returns each pixel's clamped 3x3 mean.
// Path: a pixel's results pass the stage 1, stage 2 and output registers.
// Throughput: one pixel per cycle while no result is stalled; a pixel that
// closes a row or lies on the last row holds the input until its results
// (up to 4) have gone to the output register, one result per cycle unless stalled.
// Reset: arst_n clears the pipeline and the positions; the line memory keeps
// its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_top import bbrgb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  cfg_index_t       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	bbrgb_pix_if.sink        pixels,
	bbrgb_res_if.source      blurred
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int NR  = 4;
	localparam int SW  = $clog2(NR);
	localparam int PW  = TSUM_W + RECIP_W;

	function automatic logic [CSUM_W-1:0] add3(input logic [PIX_W-1:0] x,
		input logic [PIX_W-1:0] y, input logic [PIX_W-1:0] z);
		return CSUM_W'(x) + CSUM_W'(y) + CSUM_W'(z);
	endfunction

	function automatic logic [TSUM_W-1:0] add3t(input logic [CSUM_W-1:0] x,
		input logic [CSUM_W-1:0] y, input logic [CSUM_W-1:0] z);
		return TSUM_W'(x) + TSUM_W'(y) + TSUM_W'(z);
	endfunction

	function automatic logic [PIX_W-1:0] div9(input logic [TSUM_W-1:0] x);
		logic [PW-1:0] prod;
		prod = PW'(x) * PW'(RECIP_NINE);
		return prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
	endfunction

	// Configuration and raster position.
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [CW-1:0]           last_col;
	logic [HEIGHT_REG_W-1:0] last_row;
	logic [31:0]             width32;
	logic                    in_acc;

	always_comb begin
		width32 = 32'(width_q);
		if (width32 == 32'd0) begin
			last_col = '0;
		end else if (width32 > 32'(MAX_WIDTH)) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(width32 - 32'd1);
		end
		last_row = (height_q == '0) ? '0 : height_q - HEIGHT_REG_W'(1);
	end

	assign in_acc = pixels.valid & pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr_en) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q >= last_row) ? '0 : row_q + HEIGHT_REG_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: line memory read data and position flags.
	logic                      s1_v;
	pixel_t                    pix_s1;
	logic [CW-1:0]             col_s1;
	logic                      c_zero_s1, c_one_s1, c_last_s1;
	logic                      r_zero_s1, r_one_s1, r_last_s1;
	logic                      byp_s1;
	logic [2*$bits(pixel_t)-1:0] byp_data_s1;
	logic [2*$bits(pixel_t)-1:0] rd_s1;
	logic [2*$bits(pixel_t)-1:0] line_mem [MAX_WIDTH];
	logic [2*$bits(pixel_t)-1:0] rd_data;
	logic [2*$bits(pixel_t)-1:0] wr_data;
	pixel_t                    older, recent;
	logic                      commit;
	logic                      s2_take;

	assign rd_data        = byp_s1 ? byp_data_s1 : rd_s1;
	assign {older, recent} = rd_data;
	assign wr_data        = {recent, pix_s1};
	assign commit         = s1_v & s2_take;
	assign pixels.ready   = !s1_v | s2_take;

	always_ff @(posedge clk) begin
		if (commit) begin
			line_mem[col_s1] <= wr_data;
		end
		if (in_acc) begin
			rd_s1 <= line_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_acc) begin
			s1_v <= 1'b1;
		end else if (commit) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1      <= '{red: pixels.in_red, green: pixels.in_green,
				blue: pixels.in_blue};
			col_s1      <= col_q;
			c_zero_s1   <= (col_q == '0);
			c_one_s1    <= (col_q == CW'(1));
			c_last_s1   <= (col_q == last_col);
			r_zero_s1   <= (row_q == '0);
			r_one_s1    <= (row_q == HEIGHT_REG_W'(1));
			r_last_s1   <= (row_q == last_row);
			// The entry written this cycle is the one being read.
			byp_s1      <= commit && (col_s1 == col_q);
			byp_data_s1 <= wr_data;
		end
	end

	// Column sums of the new column for the upper and the lower result row.
	csum_t  new_a, new_b;
	csum_t  a_p1_q, a_p2_q, b_p1_q, b_p2_q;
	tsum_t  tot [NR];
	logic [NR-1:0] mask;
	pixel_t top_a, top_b;

	always_comb begin
		top_a = r_one_s1 ? recent : older;
		top_b = r_zero_s1 ? pix_s1 : recent;
		new_a.red   = add3(top_a.red, recent.red, pix_s1.red);
		new_a.green = add3(top_a.green, recent.green, pix_s1.green);
		new_a.blue  = add3(top_a.blue, recent.blue, pix_s1.blue);
		new_b.red   = add3(top_b.red, pix_s1.red, pix_s1.red);
		new_b.green = add3(top_b.green, pix_s1.green, pix_s1.green);
		new_b.blue  = add3(top_b.blue, pix_s1.blue, pix_s1.blue);
	end

	always_comb begin
		tot[0].red   = add3t(c_one_s1 ? a_p1_q.red : a_p2_q.red, a_p1_q.red, new_a.red);
		tot[0].green = add3t(c_one_s1 ? a_p1_q.green : a_p2_q.green, a_p1_q.green,
			new_a.green);
		tot[0].blue  = add3t(c_one_s1 ? a_p1_q.blue : a_p2_q.blue, a_p1_q.blue,
			new_a.blue);
		tot[1].red   = add3t(c_zero_s1 ? new_a.red : a_p1_q.red, new_a.red, new_a.red);
		tot[1].green = add3t(c_zero_s1 ? new_a.green : a_p1_q.green, new_a.green,
			new_a.green);
		tot[1].blue  = add3t(c_zero_s1 ? new_a.blue : a_p1_q.blue, new_a.blue,
			new_a.blue);
		tot[2].red   = add3t(c_one_s1 ? b_p1_q.red : b_p2_q.red, b_p1_q.red, new_b.red);
		tot[2].green = add3t(c_one_s1 ? b_p1_q.green : b_p2_q.green, b_p1_q.green,
			new_b.green);
		tot[2].blue  = add3t(c_one_s1 ? b_p1_q.blue : b_p2_q.blue, b_p1_q.blue,
			new_b.blue);
		tot[3].red   = add3t(c_zero_s1 ? new_b.red : b_p1_q.red, new_b.red, new_b.red);
		tot[3].green = add3t(c_zero_s1 ? new_b.green : b_p1_q.green, new_b.green,
			new_b.green);
		tot[3].blue  = add3t(c_zero_s1 ? new_b.blue : b_p1_q.blue, new_b.blue,
			new_b.blue);
		mask = {r_last_s1 & c_last_s1, r_last_s1 & !c_zero_s1,
			!r_zero_s1 & c_last_s1, !r_zero_s1 & !c_zero_s1};
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			a_p2_q <= a_p1_q;
			a_p1_q <= new_a;
			b_p2_q <= b_p1_q;
			b_p1_q <= new_b;
		end
	end

	// Stage 2: pending results of one pixel, handed out in raster order.
	logic [NR-1:0] pend_q;
	tsum_t         tot_s2 [NR];
	logic [SW-1:0] sel;
	logic          single;
	logic          move;
	tsum_t         pick;
	logic          out_v_q;
	pixel_t        out_q;
	logic          run_last_q;

	always_comb begin
		sel = '0;
		for (int i = NR - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SW'(i);
			end
		end
	end

	assign single  = ((pend_q & (pend_q - NR'(1))) == '0);
	assign move    = (pend_q != '0) & (!out_v_q | blurred.ready);
	assign s2_take = (pend_q == '0) | (move & single);
	assign pick    = tot_s2[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (commit) begin
			pend_q <= mask;
		end else if (move) begin
			pend_q <= pend_q & ~(NR'(1) << sel);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			tot_s2 <= tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (blurred.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.red   <= div9(pick.red);
			out_q.green <= div9(pick.green);
			out_q.blue  <= div9(pick.blue);
			run_last_q  <= single;
		end
	end

	assign blurred.valid     = out_v_q;
	assign blurred.out_red   = out_q.red;
	assign blurred.out_green = out_q.green;
	assign blurred.out_blue  = out_q.blue;
	assign blurred.run_last  = run_last_q;

endmodule

// File: src/bbrgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur port checker
// Watches the result channel of the box blur top level.
// ----------------------------------------------------------------------------
module bbrgb_checker import bbrgb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] out_red,
	input logic [PIX_W-1:0] out_green,
	input logic [PIX_W-1:0] out_blue,
	input logic             out_last
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_last))
		else $error("Stalled result changed its payload.");

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Stalled result was withdrawn.");

	// Results of one pixel follow each other without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("Gap inside the results of one pixel.");

	// Nothing is offered while reset is applied.
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Result offered during reset.");

endmodule

bind box_blur_3x3_rgb_top bbrgb_checker u_bbrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (blurred.valid),
	.out_ready (blurred.ready),
	.out_red   (blurred.out_red),
	.out_green (blurred.out_green),
	.out_blue  (blurred.out_blue),
	.out_last  (blurred.run_last)
);
